FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define CSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("csm checker: property failed");

// Checks that a condition in one cycle is followed by another in the next cycle.
`define CSM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("csm checker: sequence failed");

`endif

FILE: hw/rtl/csm_pkg.sv
// Types and constants shared by the subcarrier magnitude min/max block.
package csm_pkg;

  // Field widths.
  localparam int unsigned POS_W  = 7;
  localparam int unsigned SC_W   = 6;
  localparam int unsigned AMP_W  = 16;
  localparam int unsigned ROOT_W = 32;

  // Frame layout: bytes 4..53 and 76..127 carry subcarrier pairs.
  localparam int unsigned FRAME_BYTES = 128;
  localparam logic [POS_W-1:0] LOW_FIRST  = 7'd4;
  localparam logic [POS_W-1:0] LOW_LAST   = 7'd53;
  localparam logic [POS_W-1:0] HIGH_FIRST = 7'd76;
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);

  // The root of a 32-bit radicand takes one cell for each result bit.
  localparam int unsigned ROOT_STEPS = 16;
  localparam logic [ROOT_W-1:0] ROOT_TOP_BIT = 32'h4000_0000;

  // Reset contents of the min and max tables.
  localparam logic [AMP_W-1:0] MIN_RESET = 16'hFFFF;
  localparam logic [AMP_W-1:0] MAX_RESET = 16'h0000;

  // Input item.
  typedef struct packed {
    logic signed [7:0] csi_byte;
    logic              frame_start;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [SC_W-1:0]  subcarrier;
    logic [AMP_W-1:0] amplitude;
    logic [AMP_W-1:0] min_amplitude;
    logic [AMP_W-1:0] max_amplitude;
    logic             frame_done;
  } out_t;

  // Working values handed from one root cell to the next.
  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] res;
    logic [ROOT_W-1:0] bit_w;
  } root_t;

  // Requests from the controller to the min/max table.
  typedef struct packed {
    logic            lookup;
    logic            update;
    logic [SC_W-1:0] idx;
  } tbl_ctrl_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_EMIT
  } state_e;

endpackage

FILE: hw/rtl/csi_subcarrier_magnitude_minmax_unit.sv
// Top level of the subcarrier magnitude unit with running min and max.
//
// Bytes of a channel-state buffer enter one per item; bytes at positions 4 to 53
// and 76 to 127 form imaginary/real pairs, and each pair yields one result with
// the subcarrier index, its magnitude as unsigned Q8.8 (floor of the root) and
// that subcarrier's running minimum and maximum. A byte that does not finish a
// pair leaves the block ready for the next byte. A real-part byte occupies the
// block until its result sits in the output register: the sum of squares is
// registered, a chain of 16 root cells resolves one magnitude bit per cycle, the
// root is captured, and the min/max tables are updated as the result is loaded.
// Such a byte is worked on alone: no new byte is taken until its result is
// loaded, which waits while the output register still holds an untaken result. A
// new byte is accepted while the previous result still waits to be taken.
module csi_subcarrier_magnitude_minmax_unit
  import csm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  state_e state_q;
  state_e state_d;

  logic [POS_W-1:0]  pos_q;
  logic [SC_W-1:0]   cnt_q;
  logic signed [7:0] held_im_q;

  logic [SC_W-1:0]  sub_q;
  logic             last_q;
  logic [AMP_W-1:0] sq_q;
  logic             launch_q;
  logic [AMP_W-1:0] amp_q;

  logic             out_valid_q;
  out_t             out_q;

  logic              accept;
  logic              launch;
  logic              emit;
  logic [POS_W-1:0]  pos;
  logic [SC_W-1:0]   cnt_eff;
  logic              kept;
  logic signed [15:0] im_w;
  logic signed [15:0] re_w;
  logic signed [15:0] im_sq;
  logic signed [15:0] re_sq;
  logic [AMP_W-1:0]  sq;

  tbl_ctrl_t         tbl_ctrl;
  logic [AMP_W-1:0]  tbl_min;
  logic [AMP_W-1:0]  tbl_max;

  logic              chain_vld [ROOT_STEPS+1];
  root_t             chain_dat [ROOT_STEPS+1];

  // Position decode of the incoming byte.
  always_comb begin
    pos     = in_data_i.frame_start ? '0 : pos_q;
    cnt_eff = (pos == '0) ? '0 : cnt_q;
    kept    = ((pos >= LOW_FIRST) && (pos <= LOW_LAST)) || (pos >= HIGH_FIRST);
    accept  = in_valid_i && in_ready_o;
    launch  = accept && kept && pos[0];
  end

  // Sum of squares of the held imaginary part and the incoming real part.
  always_comb begin
    im_w  = 16'(held_im_q);
    re_w  = 16'(in_data_i.csi_byte);
    im_sq = im_w * im_w;
    re_sq = re_w * re_w;
    sq    = $unsigned(im_sq) + $unsigned(re_sq);
  end

  // Controller: next state, input ready and output load.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (launch) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (chain_vld[ROOT_STEPS]) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame position, subcarrier counter and held imaginary part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cnt_q     <= '0;
      held_im_q <= '0;
      launch_q  <= 1'b0;
    end else begin
      launch_q <= launch;
      if (accept) begin
        pos_q <= (pos == LAST_POS) ? '0 : pos + 1'b1;
        cnt_q <= launch ? cnt_eff + 1'b1 : cnt_eff;
        if (kept && !pos[0]) begin
          held_im_q <= in_data_i.csi_byte;
        end
      end
    end
  end

  // Item details held while the root is worked out.
  always_ff @(posedge clk_i) begin
    if (launch) begin
      sub_q  <= cnt_eff;
      last_q <= (pos == LAST_POS);
      sq_q   <= sq;
    end
    if ((state_q == ST_ROOT) && chain_vld[ROOT_STEPS]) begin
      amp_q <= chain_dat[ROOT_STEPS].res[AMP_W-1:0];
    end
  end

  // Head of the root chain: radicand is the sum of squares scaled by 2^16.
  assign chain_vld[0]       = launch_q;
  assign chain_dat[0].rem   = {sq_q, 16'h0000};
  assign chain_dat[0].res   = '0;
  assign chain_dat[0].bit_w = ROOT_TOP_BIT;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    csm_root_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[k]),
      .data_i  (chain_dat[k]),
      .valid_o (chain_vld[k+1]),
      .data_o  (chain_dat[k+1])
    );
  end

  // Min/max tables: looked up at acceptance, updated when the result is loaded.
  assign tbl_ctrl.lookup = launch;
  assign tbl_ctrl.update = emit;
  assign tbl_ctrl.idx    = cnt_eff;

  csm_minmax_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tbl_ctrl),
    .amp_i  (amp_q),
    .min_o  (tbl_min),
    .max_o  (tbl_max)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.subcarrier    <= sub_q;
      out_q.amplitude     <= amp_q;
      out_q.min_amplitude <= tbl_min;
      out_q.max_amplitude <= tbl_max;
      out_q.frame_done    <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/csm_root_cell.sv
// One cell of the square root chain: resolves one result bit per pass.
module csm_root_cell
  import csm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  root_t data_i,
  output logic  valid_o,
  output root_t data_o
);

  logic              valid_q;
  root_t             data_q;
  root_t             data_d;
  logic [ROOT_W-1:0] trial;

  // Try to subtract the current root plus the bit under test.
  always_comb begin
    trial        = data_i.res + data_i.bit_w;
    data_d.bit_w = data_i.bit_w >> 2;
    if (data_i.rem >= trial) begin
      data_d.rem = data_i.rem - trial;
      data_d.res = (data_i.res >> 1) + data_i.bit_w;
    end else begin
      data_d.rem = data_i.rem;
      data_d.res = data_i.res >> 1;
    end
  end

  // The valid flag marks the cell that holds the item in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Working values move to the next cell every cycle.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/csm_minmax_table.sv
// Per-subcarrier running minimum and maximum tables with valid bits.
module csm_minmax_table
  import csm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_ctrl_t        ctrl_i,
  input  logic [AMP_W-1:0] amp_i,
  output logic [AMP_W-1:0] min_o,
  output logic [AMP_W-1:0] max_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned DW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (SC_W > DW) ? SC_W : DW;

  logic [AMP_W-1:0]       min_mem [TABLE_DEPTH];
  logic [AMP_W-1:0]       max_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q;

  logic [AW-1:0]    addr;
  logic [AW-1:0]    addr_q;
  logic             in_range;
  logic             in_range_q;
  logic             vld_rd_q;
  logic [AMP_W-1:0] min_rd_q;
  logic [AMP_W-1:0] max_rd_q;
  logic [AMP_W-1:0] cur_min;
  logic [AMP_W-1:0] cur_max;
  logic [AMP_W-1:0] new_min;
  logic [AMP_W-1:0] new_max;
  logic             wr_en;

  assign addr     = AW'(ctrl_i.idx);
  assign in_range = CW'(ctrl_i.idx) < CW'(TABLE_DEPTH);
  assign wr_en    = ctrl_i.update && in_range_q;

  // Registered read of both tables when a lookup is requested.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.lookup) begin
      addr_q     <= addr;
      in_range_q <= in_range;
      vld_rd_q   <= in_range && vld_q[addr];
      min_rd_q   <= min_mem[addr];
      max_rd_q   <= max_mem[addr];
    end
  end

  // An entry never written reads as its reset value.
  always_comb begin
    cur_min = vld_rd_q ? min_rd_q : MIN_RESET;
    cur_max = vld_rd_q ? max_rd_q : MAX_RESET;
    new_min = (amp_i < cur_min) ? amp_i : cur_min;
    new_max = (amp_i > cur_max) ? amp_i : cur_max;
    min_o   = in_range_q ? new_min : amp_i;
    max_o   = in_range_q ? new_max : amp_i;
  end

  // Write back the updated extremes.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      min_mem[addr_q] <= new_min;
      max_mem[addr_q] <= new_max;
    end
  end

  // Valid bits are cleared by reset and set on the first update of an entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/csm_checker.sv
// Port-level checker for the subcarrier magnitude unit and its bind.
`include "assert_macros.svh"

module csm_checker
  import csm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A stalled result stays offered unchanged.
  `CSM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // The magnitude of two signed bytes never exceeds 181.02 in Q8.8.
  `CSM_ASSERT(a_amp_range, !out_valid_o || (out_data_o.amplitude <= 16'd46340))

  // The running extremes always bracket the current magnitude.
  `CSM_ASSERT(a_minmax_order, !out_valid_o || ((out_data_o.min_amplitude <= out_data_o.amplitude) && (out_data_o.max_amplitude >= out_data_o.amplitude)))

  // The last byte of a frame always closes the last subcarrier.
  `CSM_ASSERT(a_frame_done_idx, !out_valid_o || !out_data_o.frame_done || (out_data_o.subcarrier == 6'd50))

endmodule

bind csi_subcarrier_magnitude_minmax_unit csm_checker u_csm_checker (.*);

FILE: tb/csi_subcarrier_magnitude_minmax_unit_tb.sv
// Self-checking testbench for the subcarrier magnitude unit with running min and max.
module csi_subcarrier_magnitude_minmax_unit_tb;
  import csm_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Bytes waiting to be offered, and results predicted but not yet seen.
  in_t pending_bytes[$];
  out_t expected_results[$];

  int total_items = 0;
  int n_accepted = 0;
  int errors = 0;
  int cycle_count = 0;

  // Predictor state.
  logic [POS_W-1:0] pred_pos = '0;
  logic signed [7:0] pred_imag = '0;
  logic [SC_W-1:0] pred_count = '0;
  logic [AMP_W-1:0] pred_min [TABLE_DEPTH];
  logic [AMP_W-1:0] pred_max [TABLE_DEPTH];

  csi_subcarrier_magnitude_minmax_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Clock generation.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Floor square root found by setting result bits from the top while the square fits.
  function automatic logic [AMP_W-1:0] floor_root(input logic [31:0] radicand);
    logic [AMP_W-1:0] root;
    logic [AMP_W-1:0] trial;
    root = '0;
    for (int b = AMP_W - 1; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (({16'd0, trial} * {16'd0, trial}) <= radicand) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Advances the predictor by one accepted byte and queues the result it causes.
  task automatic predict_magnitude(input in_t item);
    logic [POS_W-1:0] pos;
    logic signed [7:0] re;
    logic [31:0] sum_sq;
    logic [AMP_W-1:0] amp;
    out_t res;
    bit kept;
    if (item.frame_start) begin
      pred_pos = '0;
    end
    pos = pred_pos;
    if (pos == '0) begin
      pred_count = '0;
    end
    kept = (pos >= LOW_FIRST && pos <= LOW_LAST) || (pos >= HIGH_FIRST);
    if (kept) begin
      if (!pos[0]) begin
        pred_imag = item.csi_byte;
      end else begin
        re = item.csi_byte;
        sum_sq = 32'(int'(pred_imag) * int'(pred_imag) + int'(re) * int'(re));
        amp = floor_root(sum_sq << 16);
        res.subcarrier = pred_count;
        res.amplitude = amp;
        res.min_amplitude = amp;
        res.max_amplitude = amp;
        if (int'(pred_count) < TABLE_DEPTH) begin
          if (amp < pred_min[pred_count]) pred_min[pred_count] = amp;
          if (amp > pred_max[pred_count]) pred_max[pred_count] = amp;
          res.min_amplitude = pred_min[pred_count];
          res.max_amplitude = pred_max[pred_count];
        end
        res.frame_done = (pos == LAST_POS);
        expected_results.push_back(res);
        pred_count = pred_count + 1'b1;
      end
    end
    pred_pos = (pos == LAST_POS) ? '0 : pos + 1'b1;
  endtask

  task automatic push_byte(input logic [7:0] value, input logic start);
    in_t item;
    item.csi_byte = value;
    item.frame_start = start;
    pending_bytes.push_back(item);
  endtask

  // Random byte, with the extremes, zero and -1 drawn more often than chance gives.
  function automatic logic [7:0] pick_csi_byte();
    logic [7:0] corner [4] = '{8'h80, 8'h7F, 8'h00, 8'hFF};
    if ($urandom_range(7) == 0) begin
      return corner[$urandom_range(3)];
    end
    return 8'($urandom);
  endfunction

  // Idle percentages per phase: receiver idles more, then the sender idles more, then neither idles.
  function automatic int sender_idle_pct(input int n);
    if (n < total_items / 3) return 37;
    if (n < (2 * total_items) / 3) return 56;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(input int n);
    if (n < total_items / 3) return 56;
    if (n < (2 * total_items) / 3) return 37;
    return 0;
  endfunction

  // Driver: offers the next byte and keeps it stable until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_magnitude(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct(n_accepted)) begin
          in_valid <= 1'b1;
          in_data <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result against the oldest prediction.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result sc=%0d amp=%0d min=%0d max=%0d done=%0b", $time,
                   out_data.subcarrier, out_data.amplitude, out_data.min_amplitude,
                   out_data.max_amplitude, out_data.frame_done);
          errors++;
        end else begin
          out_t exp_res;
          exp_res = expected_results.pop_front();
          if (out_data.subcarrier !== exp_res.subcarrier ||
              out_data.amplitude !== exp_res.amplitude ||
              out_data.min_amplitude !== exp_res.min_amplitude ||
              out_data.max_amplitude !== exp_res.max_amplitude ||
              out_data.frame_done !== exp_res.frame_done) begin
            $display("%0t: mismatch expected sc=%0d amp=%0d min=%0d max=%0d done=%0b",
                     $time, exp_res.subcarrier, exp_res.amplitude, exp_res.min_amplitude,
                     exp_res.max_amplitude, exp_res.frame_done);
            $display("%0t:          actual   sc=%0d amp=%0d min=%0d max=%0d done=%0b",
                     $time, out_data.subcarrier, out_data.amplitude, out_data.min_amplitude,
                     out_data.max_amplitude, out_data.frame_done);
            errors++;
          end
        end
      end
      // One long hold-off late in the run lets the block fill and stall its input.
      if (!hold_done && n_accepted >= (5 * total_items) / 6) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct(n_accepted));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind;
    int len;
    bit with_start;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pred_min[i] = MIN_RESET;
      pred_max[i] = MAX_RESET;
    end

    // Directed: zero pair, both extreme pairs, mixed signs, then a restart mid-frame.
    push_byte(8'h11, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h00, 1'b0);  // first pair at zero: max stays at its reset value
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);  // largest magnitude
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b0);  // imaginary part dropped by the restart below
    push_byte(8'h55, 1'b1);  // frame start in the middle of a frame
    push_byte(8'hAA, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h00, 1'b0);  // equal amplitude leaves min and max unchanged
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);

    // Random: mostly whole frames, some running on without a start mark, some cut short.
    while (pending_bytes.size() < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = FRAME_BYTES;
        with_start = 1'b1;
      end else if (kind < 85) begin
        len = FRAME_BYTES;
        with_start = 1'b0;
      end else begin
        len = $urandom_range(1, FRAME_BYTES - 1);
        with_start = 1'b1;
      end
      for (int k = 0; k < len; k++) begin
        push_byte(pick_csi_byte(), with_start && (k == 0));
      end
    end
    total_items = pending_bytes.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
